>>> sv/rplw_pkg.sv
// shared types and constants for the remote packet receiver with link watch
// no dependencies; imported by every module of the block
`default_nettype none

package rplw_pkg;

    // number of header and payload bytes kept from each packet
    localparam int CAP_DEPTH = 12;
    localparam int MAX_PACKET_BYTES_DEFAULT = 32;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [7:0] OPC_STICK = 8'h01;
    localparam logic [7:0] OPC_KEY = 8'h02;
    localparam logic [7:0] REPLY_OPCODE = 8'h80;
    localparam logic [7:0] REPLY_LEN = 8'd7;
    localparam logic [7:0] RESET_FAIL_LIMIT = 8'd10;
    localparam int KEY_UNLOCK_POS = 1;

    // configuration port
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_FAIL_LIMIT = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UNLOCK_BIT = 1'd1;

    // result kinds
    localparam logic [1:0] KIND_STICK = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;
    localparam logic [1:0] KIND_LINK = 2'd3;

    // reply steps of a key command: status write first when the unlock key toggled, then seven bytes
    localparam logic [2:0] STEP_STATUS = 3'd0;
    localparam logic [2:0] STEP_SEQ_LO = 3'd1;
    localparam logic [2:0] STEP_SEQ_HI = 3'd2;
    localparam logic [2:0] STEP_LEN = 3'd3;
    localparam logic [2:0] STEP_OPCODE = 3'd4;
    localparam logic [2:0] STEP_STAT_LO = 3'd5;
    localparam logic [2:0] STEP_STAT_HI = 3'd6;
    localparam logic [2:0] STEP_SUM = 3'd7;

    typedef enum logic [1:0] {
        CMD_STICK,
        CMD_KEY,
        CMD_TICK
    } cmd_kind_t;

    typedef logic [3:0][15:0] sticks_t;

    // classified work handed from the front to the back
    typedef struct packed {
        cmd_kind_t   kind;
        logic        toggled;
        logic [15:0] status;
        logic [15:0] seq;
        sticks_t     sticks;
        logic        link;
    } cmd_t;

    // one result beat
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  reply_byte;
        logic        last;
        sticks_t     sticks;
        logic [15:0] status_word;
        logic        link;
    } res_t;

endpackage

`default_nettype wire

>>> sv/rplw_front.sv
// front end: accepts bytes and ticks, checks packets, keeps link state
// uses rplw_pkg; pushes classified commands into rplw_queue
`default_nettype none

module rplw_front
    import rplw_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire logic                   is_tick,
    input  wire logic [7:0]             byte_value,
    input  wire logic                   end_of_packet,
    input  wire logic [15:0]            control_status,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   queue_full,
    output logic                        in_ready,
    output logic                        push_valid,
    output cmd_t                        push_cmd
);

    logic [7:0]  fail_limit_reg;
    logic [3:0]  unlock_bit_reg;

    logic [7:0]  sum_reg, sum_next;
    logic [5:0]  count_reg, count_next;
    logic        overlong_reg, overlong_next;
    logic [7:0]  cap_reg [CAP_DEPTH];
    logic [7:0]  cap_next [CAP_DEPTH];
    logic [7:0]  cap_eff [CAP_DEPTH];
    sticks_t     stick_reg, stick_next;
    logic [15:0] recv_seq_reg, recv_seq_next;
    logic [15:0] seen_seq_reg, seen_seq_next;
    logic [15:0] reply_seq_reg, reply_seq_next;
    logic [7:0]  stale_reg, stale_next;
    logic        link_reg, link_next;

    logic        accept;
    logic        first;
    logic [7:0]  sum_base;
    logic        over_eff;
    logic        pkt_ok;
    logic        unlocked;
    logic [15:0] keys;
    logic [15:0] status_new;

    assign in_ready = !queue_full;
    assign accept = in_valid && in_ready;
    assign unlocked = control_status[unlock_bit_reg];

    always_comb
    begin
        first = (count_reg == 6'd0);
        sum_base = first ? 8'h00 : sum_reg;
        over_eff = (first ? 1'b0 : overlong_reg) || (count_reg >= 6'(MAX_PACKET_BYTES));
        for (int i = 0; i < CAP_DEPTH; i++)
        begin
            cap_eff[i] = first ? 8'h00 : cap_reg[i];
            if (count_reg == 6'(i))
            begin
                cap_eff[i] = byte_value;
            end
        end
        pkt_ok = !over_eff && !first && (sum_base == byte_value);
        keys = {cap_eff[5], cap_eff[4]};
        status_new = control_status;
        if (keys[KEY_UNLOCK_POS])
        begin
            status_new = control_status ^ (16'd1 << unlock_bit_reg);
        end
    end

    always_comb
    begin
        sum_next = sum_reg;
        count_next = count_reg;
        overlong_next = overlong_reg;
        cap_next = cap_reg;
        stick_next = stick_reg;
        recv_seq_next = recv_seq_reg;
        seen_seq_next = seen_seq_reg;
        reply_seq_next = reply_seq_reg;
        stale_next = stale_reg;
        link_next = link_reg;

        push_valid = 1'b0;
        push_cmd.kind = CMD_TICK;
        push_cmd.toggled = 1'b0;
        push_cmd.status = 16'h0000;
        push_cmd.seq = reply_seq_reg;
        push_cmd.sticks = stick_reg;
        push_cmd.link = link_reg;

        if (accept)
        begin
            if (is_tick)
            begin
                if (unlocked)
                begin
                    if (seen_seq_reg == recv_seq_reg)
                    begin
                        if (stale_reg < fail_limit_reg)
                        begin
                            stale_next = 8'(stale_reg + 8'd1);
                        end
                    end
                    else
                    begin
                        stale_next = 8'd0;
                        link_next = 1'b1;
                    end
                    if (stale_next >= fail_limit_reg)
                    begin
                        link_next = 1'b0;
                    end
                end
                seen_seq_next = recv_seq_reg;
                push_valid = 1'b1;
                push_cmd.kind = CMD_TICK;
                push_cmd.link = link_next;
            end
            else
            begin
                cap_next = cap_eff;
                overlong_next = over_eff;
                if (!end_of_packet)
                begin
                    if (over_eff)
                    begin
                        sum_next = sum_base;
                        count_next = count_reg;
                    end
                    else
                    begin
                        sum_next = 8'(sum_base + byte_value);
                        count_next = 6'(count_reg + 6'd1);
                    end
                end
                else
                begin
                    sum_next = sum_base;
                    count_next = 6'd0;
                    if (pkt_ok)
                    begin
                        recv_seq_next = {cap_eff[1], cap_eff[0]};
                        if (cap_eff[3] == OPC_STICK)
                        begin
                            for (int k = 0; k < 4; k++)
                            begin
                                stick_next[k] = {cap_eff[4 + 2 * k + 1], cap_eff[4 + 2 * k]};
                            end
                            push_valid = 1'b1;
                            push_cmd.kind = CMD_STICK;
                            push_cmd.sticks = stick_next;
                        end
                        else if (cap_eff[3] == OPC_KEY)
                        begin
                            reply_seq_next = 16'(reply_seq_reg + 16'd1);
                            push_valid = 1'b1;
                            push_cmd.kind = CMD_KEY;
                            push_cmd.toggled = keys[KEY_UNLOCK_POS];
                            push_cmd.status = status_new;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fail_limit_reg <= RESET_FAIL_LIMIT;
            unlock_bit_reg <= 4'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FAIL_LIMIT: fail_limit_reg <= cfg_data;
                REG_UNLOCK_BIT: unlock_bit_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= 8'h00;
            count_reg <= 6'd0;
            overlong_reg <= 1'b0;
            for (int i = 0; i < CAP_DEPTH; i++)
            begin
                cap_reg[i] <= 8'h00;
            end
            stick_reg <= '0;
            recv_seq_reg <= 16'h0000;
            seen_seq_reg <= 16'h0000;
            reply_seq_reg <= 16'h0000;
            stale_reg <= 8'd0;
            link_reg <= 1'b1;
        end
        else
        begin
            sum_reg <= sum_next;
            count_reg <= count_next;
            overlong_reg <= overlong_next;
            cap_reg <= cap_next;
            stick_reg <= stick_next;
            recv_seq_reg <= recv_seq_next;
            seen_seq_reg <= seen_seq_next;
            reply_seq_reg <= reply_seq_next;
            stale_reg <= stale_next;
            link_reg <= link_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/rplw_queue.sv
// short command queue between the front and the back end
// uses rplw_pkg for the command type
`default_nettype none

module rplw_queue
    import rplw_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      full,
    output logic      empty,
    output cmd_t      head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign head = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
            end
            case ({do_push, do_pop})
                2'b10: count_reg <= CNT_W'(count_reg + 1'b1);
                2'b01: count_reg <= CNT_W'(count_reg - 1'b1);
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/rplw_back.sv
// back end: expands queued commands into result beats, one per cycle unless out_ready stalls it
// uses rplw_pkg; drives the output register seen on the master side
`default_nettype none

module rplw_back
    import rplw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic empty,
    input  wire cmd_t head,
    output logic      pop,
    input  wire logic out_ready,
    output logic      out_valid,
    output res_t      out_res
);

    cmd_t       cmd_reg;
    logic       active_reg, active_next;
    logic [2:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    res_t       res_reg;

    cmd_t       cur;
    logic [2:0] step;
    logic [7:0] reply_sum;
    logic       out_free;
    logic       emit;
    res_t       res;

    always_comb
    begin
        cur = active_reg ? cmd_reg : head;
        if (active_reg)
        begin
            step = step_reg;
        end
        else if (head.kind == CMD_KEY && !head.toggled)
        begin
            step = STEP_SEQ_LO;
        end
        else
        begin
            step = STEP_STATUS;
        end

        reply_sum = 8'(cur.seq[7:0] + cur.seq[15:8] + REPLY_LEN + REPLY_OPCODE
                       + cur.status[7:0] + cur.status[15:8]);

        res.kind = KIND_LINK;
        res.reply_byte = 8'h00;
        res.last = 1'b1;
        res.sticks = cur.sticks;
        res.status_word = 16'h0000;
        res.link = cur.link;
        case (cur.kind)
            CMD_STICK: res.kind = KIND_STICK;
            CMD_TICK: res.kind = KIND_LINK;
            CMD_KEY:
            begin
                res.last = (step == STEP_SUM);
                if (step == STEP_STATUS)
                begin
                    res.kind = KIND_STATUS;
                    res.status_word = cur.status;
                end
                else
                begin
                    res.kind = KIND_REPLY;
                    case (step)
                        STEP_SEQ_LO: res.reply_byte = cur.seq[7:0];
                        STEP_SEQ_HI: res.reply_byte = cur.seq[15:8];
                        STEP_LEN: res.reply_byte = REPLY_LEN;
                        STEP_OPCODE: res.reply_byte = REPLY_OPCODE;
                        STEP_STAT_LO: res.reply_byte = cur.status[7:0];
                        STEP_STAT_HI: res.reply_byte = cur.status[15:8];
                        STEP_SUM: res.reply_byte = reply_sum;
                        default: res.reply_byte = 8'h00;
                    endcase
                end
            end
            default: ;
        endcase
    end

    // the output register is free when it holds no beat or its beat is taken this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign emit = out_free && (active_reg || !empty);
    assign pop = emit && !active_reg;

    always_comb
    begin
        active_next = active_reg;
        step_next = step_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            active_next = !res.last;
            step_next = 3'(step + 3'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (emit)
        begin
            res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            step_reg <= STEP_STATUS;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            step_reg <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res = res_reg;

endmodule

`default_nettype wire

>>> sv/remote_packet_receiver_link_watch.sv
// top level of the remote packet receiver with link watch
// instantiates rplw_front, rplw_queue and rplw_back; uses rplw_pkg
//
//  channel   | direction | beat contents
//  ----------+-----------+-------------------------------------------------
//  s_*       | in        | packet byte or tick, end mark, status word
//  m_*       | out       | stick update, reply byte, status write, link state
//  cfg_*     | in        | register write: fail_limit (0), unlock_bit (1)
//
// the front takes one beat per cycle while the command queue has room and
// finishes all packet and link state work in that cycle; the back sends one
// result per cycle unless m_tready stalls it; a key packet gives seven reply
// bytes. s_tready drops only when the queue is full. reset is asynchronous
// and clears control state, not queue or output data; no clearing pass follows
`default_nettype none

module remote_packet_receiver_link_watch
    import rplw_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [23:0]            s_tdata,  // byte_value, control_status
    input  wire logic                   s_tlast,  // end_of_packet
    input  wire logic [0:0]             s_tuser,  // op
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // reply_byte, throttle, yaw, roll, pitch, status_word, link_ok, zero fill
    output logic [95:0]                 m_tdata,
    output logic                        m_tlast,  // reply_last
    output logic [1:0]                  m_tuser,  // kind
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    logic push_valid;
    cmd_t push_cmd;
    logic queue_full;
    logic queue_empty;
    cmd_t queue_head;
    logic pop;
    res_t res;

    rplw_front #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .is_tick        (s_tuser[0]),
        .byte_value     (s_tdata[7:0]),
        .end_of_packet  (s_tlast),
        .control_status (s_tdata[23:8]),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .queue_full     (queue_full),
        .in_ready       (s_tready),
        .push_valid     (push_valid),
        .push_cmd       (push_cmd)
    );

    rplw_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push_valid),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (queue_full),
        .empty    (queue_empty),
        .head     (queue_head)
    );

    rplw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .head      (queue_head),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (res)
    );

    assign m_tdata = {7'b0, res.link, res.status_word, res.sticks[3], res.sticks[2],
                      res.sticks[1], res.sticks[0], res.reply_byte};
    assign m_tlast = res.last;
    assign m_tuser = res.kind;

endmodule

`default_nettype wire
